// ----- sv/egdc_pkg.sv -----
package egdc_pkg;
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_UP   = 2'd1;
    localparam logic [1:0] MODE_DOWN = 2'd2;
    localparam logic [1:0] MODE_DOOR = 2'd3;
    localparam logic [1:0] HEAD_UP   = 2'd0;
    localparam logic [1:0] HEAD_DOWN = 2'd1;
    localparam logic [1:0] HEAD_NONE = 2'd2;
    localparam logic [1:0] DISP_ZERO    = 2'd0;
    localparam logic [1:0] DISP_NEAREST = 2'd1;
    localparam logic [1:0] DISP_LOAD    = 2'd2;
    localparam logic       OP_REQUEST = 1'b0;
    localparam logic       OP_TICK    = 1'b1;
    localparam logic       CFG_DISPATCH_MODE = 1'b0;
    localparam logic       CFG_CARS_IN_USE   = 1'b1;
    localparam int unsigned WRONG_WAY_PENALTY = 10000;

    typedef struct packed {
        logic       opcode;
        logic [3:0] floor;
        logic [1:0] direction;
    } cmd_t;

    typedef struct packed {
        logic [2:0] car;
        logic       accepted;
        logic [3:0] car_floor;
        logic [1:0] car_mode;
        logic [1:0] car_heading;
        logic [5:0] pending;
        logic       last;
    } result_t;
endpackage

// ----- sv/egdc_front.sv -----
// Accepts input requests, normalizes fields and pushes them into a two-entry queue.
module egdc_front #(
    parameter int NUM_FLOORS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,
    input  logic              s_axis_tuser,
    output logic              q_valid,
    input  logic              q_ready,
    output egdc_pkg::cmd_t    q_cmd
);
    import egdc_pkg::*;

    cmd_t       ent_reg [2];
    cmd_t       in_cmd;
    logic [1:0] cnt_reg;
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic       push;
    logic       pop;
    logic [3:0] fl_in;
    logic [1:0] dir_in;

    always_comb begin
        fl_in  = s_axis_tdata[3:0];
        dir_in = s_axis_tdata[5:4];
        if (32'(fl_in) > NUM_FLOORS - 1) begin
            fl_in = 4'(NUM_FLOORS - 1);
        end
        if (dir_in == 2'd3) begin
            dir_in = HEAD_NONE;
        end
        in_cmd.opcode    = s_axis_tuser;
        in_cmd.floor     = fl_in;
        in_cmd.direction = dir_in;
    end

    assign s_axis_tready = (cnt_reg != 2'd2);
    assign push  = s_axis_tvalid && s_axis_tready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop   = q_valid && q_ready;
    assign q_cmd = ent_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end else begin
            if (push) begin
                ent_reg[wr_ptr_reg] <= in_cmd;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ----- sv/egdc_back.sv -----
// Executes one queued command at a time: requests by scoring, then updating;
// ticks by updating all cars, then reporting one car per cycle unless stalled.
module egdc_back #(
    parameter int NUM_CARS   = 4,
    parameter int NUM_FLOORS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [3:0]        cfg_wdata,
    input  logic              q_valid,
    output logic              q_ready,
    input  egdc_pkg::cmd_t    q_cmd,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,
    output logic              m_axis_tlast
);
    import egdc_pkg::*;

    localparam int CW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
    localparam int FW = $clog2(NUM_FLOORS);
    localparam int NW = $clog2(NUM_CARS + 1);
    localparam int SW = 15;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_APPLY  = 2'd1;
    localparam logic [1:0] ST_REPORT = 2'd2;

    logic [1:0]            st_reg;
    logic [1:0]            disp_reg;
    logic [3:0]            ncfg_reg;
    logic [FW-1:0]         flr_reg  [NUM_CARS];
    logic [1:0]            mode_reg [NUM_CARS];
    logic [1:0]            head_reg [NUM_CARS];
    logic [NUM_FLOORS-1:0] up_reg   [NUM_CARS];
    logic [NUM_FLOORS-1:0] dn_reg   [NUM_CARS];
    logic [CW-1:0]         pick_reg;
    logic [CW-1:0]         idx_reg;
    logic [FW-1:0]         rfl_reg;
    logic [1:0]            rdir_reg;
    logic                  out_valid_reg;
    result_t               out_reg;
    logic [NW-1:0]         n_act;
    logic                  out_free;
    logic [SW-1:0]         score [NUM_CARS];
    logic [CW-1:0]         best;
    logic [SW-1:0]         best_s;
    logic [FW-1:0]         fl_req;

    function automatic logic [6:0] popc(input logic [NUM_FLOORS-1:0] v);
        logic [6:0] n;
        n = '0;
        for (int k = 0; k < NUM_FLOORS; k++) n = n + 7'(v[k]);
        return n;
    endfunction

    function automatic logic [FW-1:0] lowf(input logic [NUM_FLOORS-1:0] v);
        logic [FW-1:0] f;
        f = FW'(NUM_FLOORS - 1);
        for (int k = NUM_FLOORS - 1; k >= 0; k--) if (v[k]) f = FW'(k);
        return f;
    endfunction

    function automatic logic [FW-1:0] highf(input logic [NUM_FLOORS-1:0] v);
        logic [FW-1:0] f;
        f = '0;
        for (int k = 0; k < NUM_FLOORS; k++) if (v[k]) f = FW'(k);
        return f;
    endfunction

    function automatic logic [FW-1:0] dst(input logic [FW-1:0] a, input logic [FW-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    assign n_act  = (32'(ncfg_reg) > NUM_CARS) ? NW'(NUM_CARS) : NW'(ncfg_reg);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign q_ready = (st_reg == ST_IDLE) && out_free;
    assign fl_req = FW'(q_cmd.floor);

    // Scores for every car in parallel; selection keeps the first minimum.
    always_comb begin
        for (int i = 0; i < NUM_CARS; i++) begin
            logic good;
            good = mode_reg[i] == MODE_IDLE || head_reg[i] == HEAD_NONE ||
                   (head_reg[i] == HEAD_UP && q_cmd.direction == HEAD_UP &&
                    flr_reg[i] <= fl_req) ||
                   (head_reg[i] == HEAD_DOWN && q_cmd.direction == HEAD_DOWN &&
                    flr_reg[i] >= fl_req);
            if (disp_reg == DISP_NEAREST) begin
                score[i] = SW'(dst(flr_reg[i], fl_req)) +
                           (good ? SW'(0) : SW'(WRONG_WAY_PENALTY));
            end else begin
                score[i] = SW'(popc(up_reg[i])) + SW'(popc(dn_reg[i]));
            end
        end
        best   = '0;
        best_s = '1;
        if (disp_reg == DISP_NEAREST || disp_reg == DISP_LOAD) begin
            for (int i = 0; i < NUM_CARS; i++) begin
                if (NW'(i) < n_act && score[i] < best_s) begin
                    best_s = score[i];
                    best   = CW'(i);
                end
            end
        end
    end

    function automatic result_t rep(input logic [CW-1:0] c, input logic acc,
                                    input logic lst, input logic [FW-1:0] f,
                                    input logic [1:0] m, input logic [1:0] h,
                                    input logic [NUM_FLOORS-1:0] u,
                                    input logic [NUM_FLOORS-1:0] d);
        result_t r;
        logic [7:0] p;
        p = 8'(popc(u)) + 8'(popc(d));
        r.car         = 3'(c);
        r.accepted    = acc;
        r.car_floor   = 4'(f);
        r.car_mode    = m;
        r.car_heading = h;
        r.pending     = (p > 8'd63) ? 6'd63 : p[5:0];
        r.last        = lst;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        logic emit;
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            disp_reg      <= DISP_ZERO;
            ncfg_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CARS; i++) begin
                flr_reg[i]  <= '0;
                mode_reg[i] <= MODE_IDLE;
                head_reg[i] <= HEAD_NONE;
                up_reg[i]   <= '0;
                dn_reg[i]   <= '0;
            end
        end else begin
            emit = 1'b0;
            if (cfg_we) begin
                if (cfg_addr == CFG_DISPATCH_MODE) begin
                    disp_reg <= (cfg_wdata[1:0] == 2'd3) ? DISP_ZERO : cfg_wdata[1:0];
                end else begin
                    ncfg_reg <= cfg_wdata;
                end
            end
            case (st_reg)
                ST_IDLE: begin
                    if (q_valid && out_free) begin
                        if (q_cmd.opcode == OP_REQUEST) begin
                            if (n_act == '0) begin
                                out_reg <= '{last: 1'b1, default: '0};
                                emit = 1'b1;
                            end else begin
                                pick_reg <= best;
                                rfl_reg  <= fl_req;
                                rdir_reg <= q_cmd.direction;
                                st_reg   <= ST_APPLY;
                            end
                        end else if (n_act != '0) begin
                            for (int i = 0; i < NUM_CARS; i++) begin
                                if (NW'(i) < n_act) begin
                                    logic [FW-1:0] nf;
                                    nf = flr_reg[i];
                                    case (mode_reg[i])
                                        MODE_UP: begin
                                            if (32'(nf) < NUM_FLOORS - 1) nf = nf + 1'b1;
                                            flr_reg[i] <= nf;
                                            if (up_reg[i][nf]) begin
                                                up_reg[i][nf] <= 1'b0;
                                                mode_reg[i]   <= MODE_DOOR;
                                            end
                                        end
                                        MODE_DOWN: begin
                                            if (nf != '0) nf = nf - 1'b1;
                                            flr_reg[i] <= nf;
                                            if (dn_reg[i][nf]) begin
                                                dn_reg[i][nf] <= 1'b0;
                                                mode_reg[i]   <= MODE_DOOR;
                                            end
                                        end
                                        MODE_DOOR: begin
                                            if (head_reg[i] != HEAD_DOWN) begin
                                                if (up_reg[i] != '0) begin
                                                    head_reg[i] <= HEAD_UP;
                                                    mode_reg[i] <= MODE_UP;
                                                end else if (dn_reg[i] != '0) begin
                                                    head_reg[i] <= HEAD_DOWN;
                                                    mode_reg[i] <= MODE_DOWN;
                                                end else begin
                                                    head_reg[i] <= HEAD_NONE;
                                                    mode_reg[i] <= MODE_IDLE;
                                                end
                                            end else begin
                                                if (dn_reg[i] != '0) begin
                                                    head_reg[i] <= HEAD_DOWN;
                                                    mode_reg[i] <= MODE_DOWN;
                                                end else if (up_reg[i] != '0) begin
                                                    head_reg[i] <= HEAD_UP;
                                                    mode_reg[i] <= MODE_UP;
                                                end else begin
                                                    head_reg[i] <= HEAD_NONE;
                                                    mode_reg[i] <= MODE_IDLE;
                                                end
                                            end
                                        end
                                        default: ;
                                    endcase
                                end
                            end
                            idx_reg <= '0;
                            st_reg  <= ST_REPORT;
                        end
                    end
                end
                ST_APPLY: begin
                    if (out_free) begin
                        logic [NUM_FLOORS-1:0] u, d;
                        logic [1:0] m, h;
                        logic [FW-1:0] cf;
                        cf = flr_reg[pick_reg];
                        u  = up_reg[pick_reg];
                        d  = dn_reg[pick_reg];
                        m  = mode_reg[pick_reg];
                        h  = head_reg[pick_reg];
                        if (rfl_reg == cf && m == MODE_IDLE) begin
                            m = MODE_DOOR;
                        end else begin
                            if (rdir_reg == HEAD_UP ||
                                (rdir_reg != HEAD_DOWN && rfl_reg > cf)) begin
                                u[rfl_reg] = 1'b1;
                            end else begin
                                d[rfl_reg] = 1'b1;
                            end
                            if (m == MODE_IDLE) begin
                                if (u != '0 && (d == '0 ||
                                    dst(lowf(u), cf) <= dst(highf(d), cf))) begin
                                    h = HEAD_UP;
                                    m = MODE_UP;
                                end else begin
                                    h = HEAD_DOWN;
                                    m = MODE_DOWN;
                                end
                            end
                        end
                        up_reg[pick_reg]   <= u;
                        dn_reg[pick_reg]   <= d;
                        mode_reg[pick_reg] <= m;
                        head_reg[pick_reg] <= h;
                        out_reg <= rep(pick_reg, 1'b1, 1'b1, cf, m, h, u, d);
                        emit = 1'b1;
                        st_reg  <= ST_IDLE;
                    end
                end
                ST_REPORT: begin
                    if (out_free) begin
                        logic lst;
                        lst = (NW'(idx_reg) + 1'b1) == n_act;
                        out_reg <= rep(idx_reg, 1'b0, lst, flr_reg[idx_reg],
                                       mode_reg[idx_reg], head_reg[idx_reg],
                                       up_reg[idx_reg], dn_reg[idx_reg]);
                        emit = 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                        if (lst) st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {6'd0, out_reg.pending, out_reg.car_heading,
                            out_reg.car_mode, out_reg.car_floor, out_reg.accepted,
                            out_reg.car};
endmodule

// ----- sv/elevator_group_dispatch_controller.sv -----
// Elevator group dispatcher. Input items enter a two-entry queue and are
// carried out one at a time by the car engine. A hall request goes through
// car selection, then update, and gives one result; a tick updates all cars
// at once and then reports one car per cycle while the output is not
// stalled, one report for each car in use (cars_in_use, capped at NUM_CARS).
// The queue keeps accepting items while a result still waits, until it is full.
// cfg_addr 0 is dispatch_mode, 1 is cars_in_use.
module elevator_group_dispatch_controller #(
    parameter int NUM_CARS   = 4,
    parameter int NUM_FLOORS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // floor[3:0], direction[5:4]
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // car[2:0], accepted, car_floor[3:0], car_mode[1:0], car_heading[1:0], pending[5:0]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import egdc_pkg::*;

    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    egdc_front #(.NUM_FLOORS(NUM_FLOORS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    egdc_back #(.NUM_CARS(NUM_CARS), .NUM_FLOORS(NUM_FLOORS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );
endmodule

// ----- sv/egdc_checker.sv -----
module egdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_acc_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tlast)
        else $error("assigned request not last");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[23:18] == 6'd0)
        else $error("pad bits set");
    a_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[17:12] <= 6'd32)
        else $error("pending out of range");
endmodule

bind elevator_group_dispatch_controller egdc_checker u_chk (.*);

// ----- dv/tb_elevator_group_dispatch_controller.sv -----
`default_nettype none

module tb_elevator_group_dispatch_controller;
    timeunit 1ns;
    timeprecision 1ps;
    import egdc_pkg::*;

    localparam int NCARS = 4;
    localparam int NFLOORS = 16;
    localparam int STALL_LIMIT = 3000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_addr;
    logic [3:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    elevator_group_dispatch_controller dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // Shadow copy of the group state.
    logic [1:0]  sh_dispatch;
    logic [3:0]  sh_cars;
    logic [3:0]  sh_floor [NCARS];
    logic [1:0]  sh_mode [NCARS];
    logic [1:0]  sh_head [NCARS];
    logic [15:0] sh_up [NCARS];
    logic [15:0] sh_down [NCARS];

    result_t status_q[$];
    int      fail_cnt = 0;
    int      req_cnt = 0;
    int      status_cnt = 0;
    int      quiet_cycles = 0;
    bit      no_idle = 0;

    typedef struct {
        bit         is_cfg;
        logic       addr;
        logic [3:0] wdata;
        logic       opcode;
        logic [3:0] floor;
        logic [1:0] direction;
        bit         has_typed;
        result_t    typed;
    } step_row_t;

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    function automatic int unsigned load_of(int c);
        return $countones(sh_up[c]) + $countones(sh_down[c]);
    endfunction

    function automatic int unsigned floor_gap(logic [3:0] a, logic [3:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [3:0] low_floor(logic [15:0] m);
        for (int f = 0; f < NFLOORS; f++) if (m[f]) return 4'(f);
        return 4'd0;
    endfunction

    function automatic logic [3:0] high_floor(logic [15:0] m);
        for (int f = NFLOORS - 1; f >= 0; f--) if (m[f]) return 4'(f);
        return 4'd0;
    endfunction

    function automatic result_t car_status(int c, logic acc, logic lst);
        result_t r;
        int unsigned p;
        p = load_of(c);
        r.car = 3'(c);
        r.accepted = acc;
        r.car_floor = sh_floor[c];
        r.car_mode = sh_mode[c];
        r.car_heading = sh_head[c];
        r.pending = (p > 63) ? 6'd63 : 6'(p);
        r.last = lst;
        return r;
    endfunction

    function automatic int choose_car(int n, logic [3:0] fl, logic [1:0] dir);
        int best;
        int unsigned best_score, s;
        bit good;
        best = 0;
        best_score = 32'hffff_ffff;
        for (int i = 0; i < n; i++) begin
            if (sh_dispatch == DISP_NEAREST) begin
                s = floor_gap(sh_floor[i], fl);
                good = sh_mode[i] == MODE_IDLE || sh_head[i] == HEAD_NONE ||
                       (sh_head[i] == HEAD_UP && dir == HEAD_UP && sh_floor[i] <= fl) ||
                       (sh_head[i] == HEAD_DOWN && dir == HEAD_DOWN && sh_floor[i] >= fl);
                if (!good) s += WRONG_WAY_PENALTY;
            end else if (sh_dispatch == DISP_LOAD) begin
                s = load_of(i);
            end else begin
                s = 0;
            end
            if (s < best_score) begin
                best_score = s;
                best = i;
            end
        end
        return best;
    endfunction

    function automatic void hall_call(int c, logic [3:0] fl, logic [1:0] dir);
        logic [3:0] cf;
        cf = sh_floor[c];
        if (fl == cf && sh_mode[c] == MODE_IDLE) begin
            sh_mode[c] = MODE_DOOR;
            return;
        end
        if (dir == HEAD_UP || (dir != HEAD_DOWN && fl > cf)) sh_up[c][fl] = 1'b1;
        else sh_down[c][fl] = 1'b1;
        if (sh_mode[c] == MODE_IDLE) begin
            if (sh_up[c] != 0 && (sh_down[c] == 0 ||
                floor_gap(low_floor(sh_up[c]), cf) <= floor_gap(high_floor(sh_down[c]), cf))) begin
                sh_head[c] = HEAD_UP;
                sh_mode[c] = MODE_UP;
            end else begin
                sh_head[c] = HEAD_DOWN;
                sh_mode[c] = MODE_DOWN;
            end
        end
    endfunction

    function automatic void move_car(int c);
        bit prefer_up;
        case (sh_mode[c])
            MODE_UP: begin
                if (sh_floor[c] < NFLOORS - 1) sh_floor[c]++;
                if (sh_up[c][sh_floor[c]]) begin
                    sh_up[c][sh_floor[c]] = 1'b0;
                    sh_mode[c] = MODE_DOOR;
                end
            end
            MODE_DOWN: begin
                if (sh_floor[c] > 0) sh_floor[c]--;
                if (sh_down[c][sh_floor[c]]) begin
                    sh_down[c][sh_floor[c]] = 1'b0;
                    sh_mode[c] = MODE_DOOR;
                end
            end
            MODE_DOOR: begin
                prefer_up = sh_head[c] != HEAD_DOWN;
                if (prefer_up ? sh_up[c] != 0 : sh_down[c] != 0) begin
                    sh_head[c] = prefer_up ? HEAD_UP : HEAD_DOWN;
                    sh_mode[c] = prefer_up ? MODE_UP : MODE_DOWN;
                end else if (prefer_up ? sh_down[c] != 0 : sh_up[c] != 0) begin
                    sh_head[c] = prefer_up ? HEAD_DOWN : HEAD_UP;
                    sh_mode[c] = prefer_up ? MODE_DOWN : MODE_UP;
                end else begin
                    sh_head[c] = HEAD_NONE;
                    sh_mode[c] = MODE_IDLE;
                end
            end
            default: ;
        endcase
    endfunction

    // Updates the shadow state for one accepted request and queues its results.
    function automatic void predict_status(logic op, logic [3:0] fl, logic [1:0] dir_in);
        int n, c;
        logic [1:0] dir;
        result_t r;
        n = (sh_cars > NCARS) ? NCARS : sh_cars;
        dir = (dir_in > HEAD_NONE) ? HEAD_NONE : dir_in;
        if (op == OP_REQUEST) begin
            if (n == 0) begin
                r = '0;
                r.last = 1'b1;
                status_q = {status_q, r};
                return;
            end
            c = choose_car(n, fl, dir);
            hall_call(c, fl, dir);
            status_q = {status_q, car_status(c, 1'b1, 1'b1)};
        end else begin
            for (int i = 0; i < n; i++) move_car(i);
            for (int i = 0; i < n; i++) status_q = {status_q, car_status(i, 1'b0, i + 1 == n)};
        end
    endfunction

    function automatic void compare_status(result_t e, result_t a);
        if (a.car != e.car) begin
            $error("car: expected %0d, got %0d", e.car, a.car); fail_cnt++;
        end
        if (a.accepted != e.accepted) begin
            $error("accepted: expected %0d, got %0d", e.accepted, a.accepted); fail_cnt++;
        end
        if (a.car_floor != e.car_floor) begin
            $error("car_floor: expected %0d, got %0d", e.car_floor, a.car_floor); fail_cnt++;
        end
        if (a.car_mode != e.car_mode) begin
            $error("car_mode: expected %0d, got %0d", e.car_mode, a.car_mode); fail_cnt++;
        end
        if (a.car_heading != e.car_heading) begin
            $error("car_heading: expected %0d, got %0d", e.car_heading, a.car_heading);
            fail_cnt++;
        end
        if (a.pending != e.pending) begin
            $error("pending: expected %0d, got %0d", e.pending, a.pending); fail_cnt++;
        end
        if (a.last != e.last) begin
            $error("last: expected %0d, got %0d", e.last, a.last); fail_cnt++;
        end
    endfunction

    // Result side: random back-pressure and checking.
    always @(posedge aclk) begin
        result_t got;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(99) >= 20);
            if (m_axis_tvalid && m_axis_tready) begin
                got.car = m_axis_tdata[2:0];
                got.accepted = m_axis_tdata[3];
                got.car_floor = m_axis_tdata[7:4];
                got.car_mode = m_axis_tdata[9:8];
                got.car_heading = m_axis_tdata[11:10];
                got.pending = m_axis_tdata[17:12];
                got.last = m_axis_tlast;
                status_cnt++;
                if (status_q.size() == 0) begin
                    $error("car status with no request outstanding");
                    fail_cnt++;
                end else begin
                    compare_status(status_q.pop_front(), got);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || status_q.size() == 0 && !s_axis_tvalid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_elevator_group_dispatch_controller NOT OK");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        while (status_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic addr, logic [3:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (addr == CFG_DISPATCH_MODE) sh_dispatch = (value[1:0] == 2'd3) ? DISP_ZERO : value[1:0];
        else sh_cars = value;
    endtask

    task automatic send_request(logic op, logic [3:0] fl, logic [1:0] dir);
        if (!no_idle && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b0, dir, fl};
        s_axis_tuser <= op;
        do @(posedge aclk); while (!s_axis_tready);
        req_cnt++;
        predict_status(op, fl, dir);
    endtask

    step_row_t rows[$];
    result_t   door_at_zero;

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        sh_dispatch = DISP_ZERO;
        sh_cars = 0;
        for (int i = 0; i < NCARS; i++) begin
            sh_floor[i] = 0; sh_mode[i] = MODE_IDLE; sh_head[i] = HEAD_NONE;
            sh_up[i] = 0; sh_down[i] = 0;
        end
        door_at_zero = '{car: 0, accepted: 1, car_floor: 0, car_mode: MODE_DOOR,
                         car_heading: HEAD_NONE, pending: 0, last: 1};

        // Directed rows: no cars installed, then extremes, every mode and direction.
        rows = '{
            '{0, 0, 0, OP_REQUEST, 4'd15, 2'd3, 1, result_t'{last: 1, default: 0}},
            '{0, 0, 0, OP_TICK,    4'd0,  HEAD_NONE, 0, '0},
            '{1, CFG_CARS_IN_USE,   4'd4, 0, 0, 0, 0, '0},
            '{1, CFG_DISPATCH_MODE, 4'(DISP_NEAREST), 0, 0, 0, 0, '0},
            '{0, 0, 0, OP_REQUEST, 4'd0,  HEAD_NONE, 1, door_at_zero},
            '{0, 0, 0, OP_REQUEST, 4'd15, HEAD_UP,   0, '0},
            '{0, 0, 0, OP_REQUEST, 4'd9,  2'd3,      0, '0},
            '{0, 0, 0, OP_TICK,    4'd0,  HEAD_NONE, 0, '0},
            '{0, 0, 0, OP_REQUEST, 4'd0,  HEAD_DOWN, 0, '0},
            '{0, 0, 0, OP_TICK,    4'd15, 2'd3,      0, '0},
            '{0, 0, 0, OP_REQUEST, 4'd7,  HEAD_DOWN, 0, '0},
            '{1, CFG_DISPATCH_MODE, 4'(DISP_LOAD), 0, 0, 0, 0, '0},
            '{0, 0, 0, OP_REQUEST, 4'd3,  HEAD_UP,   0, '0},
            '{0, 0, 0, OP_REQUEST, 4'd12, HEAD_DOWN, 0, '0},
            '{0, 0, 0, OP_TICK,    4'd0,  HEAD_NONE, 0, '0},
            '{1, CFG_DISPATCH_MODE, 4'd3, 0, 0, 0, 0, '0},
            '{1, CFG_CARS_IN_USE,   4'd8, 0, 0, 0, 0, '0},
            '{0, 0, 0, OP_REQUEST, 4'd15, HEAD_NONE, 0, '0},
            '{0, 0, 0, OP_TICK,    4'd0,  HEAD_NONE, 0, '0},
            '{0, 0, 0, OP_TICK,    4'd0,  HEAD_NONE, 0, '0},
            '{0, 0, 0, OP_TICK,    4'd0,  HEAD_NONE, 0, '0}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[k]) begin
            if (rows[k].is_cfg) begin
                s_axis_tvalid <= 1'b0;
                write_reg(rows[k].addr, rows[k].wdata);
            end else begin
                if (rows[k].has_typed) begin
                    s_axis_tvalid <= 1'b0;
                    wait_idle();
                end
                send_request(rows[k].opcode, rows[k].floor, rows[k].direction);
                if (rows[k].has_typed) compare_status(status_q[$], rows[k].typed);
            end
        end

        // Random phases, each after writing both registers; dispatch mode cycles through all four codes.
        for (int ph = 0; ph < 8; ph++) begin
            s_axis_tvalid <= 1'b0;
            write_reg(CFG_DISPATCH_MODE, 4'(ph % 4));
            write_reg(CFG_CARS_IN_USE,
                      4'((ph == 3) ? 0 : (ph == 5) ? 8 : $urandom_range(1, 4)));
            no_idle = (ph == 6);
            for (int k = 0; k < 18; k++) begin
                send_request($urandom_range(99) < 45 ? OP_TICK : OP_REQUEST,
                             4'($urandom_range(15)), 2'($urandom_range(3)));
            end
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 0;
        wait_idle();

        $display("Sent %0d requests and ticks over 8 register settings; checked %0d car results.",
                 req_cnt, status_cnt);
        if (fail_cnt == 0) begin
            $display("tb_elevator_group_dispatch_controller OK");
        end else begin
            $display("tb_elevator_group_dispatch_controller NOT OK");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ----- elevator_group_dispatch_controller.f -----
sv/egdc_pkg.sv
sv/egdc_front.sv
sv/egdc_back.sv
sv/elevator_group_dispatch_controller.sv
sv/egdc_checker.sv
dv/tb_elevator_group_dispatch_controller.sv
